FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NFCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NFCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/core/nfcd_pkg.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder package
// Widths, operation codes, command bytes and register indexes.
// ----------------------------------------------------------------------------
package nfcd_pkg;

  localparam int unsigned AddrW   = 22;
  localparam int unsigned DataW   = 16;
  localparam int unsigned OpW     = 3;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  typedef enum logic [OpW-1:0] {
    OpNone    = 3'd0,
    OpRead    = 3'd1,
    OpIdRead  = 3'd2,
    OpProgram = 3'd3,
    OpSector  = 3'd4,
    OpBlock   = 3'd5,
    OpChip    = 3'd6
  } op_e;

  // Unlock addresses, compared on the low 16 word-address bits.
  localparam logic [15:0] UnlockAddrA = 16'h5555;
  localparam logic [15:0] UnlockAddrB = 16'h2AAA;

  localparam logic [7:0] CmdUnlockA  = 8'hAA;
  localparam logic [7:0] CmdUnlockB  = 8'h55;
  localparam logic [7:0] CmdIdEntry  = 8'h90;
  localparam logic [7:0] CmdExit     = 8'hF0;
  localparam logic [7:0] CmdProgram  = 8'hA0;
  localparam logic [7:0] CmdErase    = 8'h80;
  localparam logic [7:0] CmdChip     = 8'h10;
  localparam logic [7:0] CmdEraseLo  = 8'h30;
  localparam logic [7:0] CmdEraseHi  = 8'h50;

  localparam logic [DataW-1:0] MakerIdReset = 16'h00BF;
  localparam logic [DataW-1:0] PartIdReset  = 16'h2782;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegMakerId   = 2'd0;
  localparam logic [1:0] RegPartId    = 2'd1;
  localparam logic [1:0] RegEraseSwap = 2'd2;

endpackage

FILE: rtl/core/nfcd_in_if.sv
// ----------------------------------------------------------------------------
// Bus access channel
// Valid/ready channel carrying one decoded bus access per word.
// ----------------------------------------------------------------------------
interface nfcd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [nfcd_pkg::AddrW-1:0]  word_address;
  logic [nfcd_pkg::DataW-1:0]  write_data;

  modport source (output valid, kind, word_address, write_data, input ready);
  modport sink   (input valid, kind, word_address, write_data, output ready);
endinterface

FILE: rtl/core/nfcd_out_if.sv
// ----------------------------------------------------------------------------
// Flash operation channel
// Valid/ready channel carrying one array operation per word.
// ----------------------------------------------------------------------------
interface nfcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfcd_pkg::OpW-1:0]    operation;
  logic [nfcd_pkg::AddrW-1:0]  target_address;
  logic [nfcd_pkg::DataW-1:0]  result_data;

  modport source (output valid, operation, target_address, result_data, input ready);
  modport sink   (input valid, operation, target_address, result_data, output ready);
endinterface

FILE: rtl/core/nor_flash_command_decoder_core.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder core
// Decodes bus accesses against the unlock/command protocol into array ops.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result side does not stall; the
// decode sits between the input register and the result register, and the
// sequence state updates as a word moves on.
// Reset: asynchronous; clears both stages, the sequence step and ID mode, and
// loads the registers with their reset values.
module nor_flash_command_decoder_core #(
  parameter int unsigned ADDR_BITS = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nfcd_in_if.sink                       in_i,
  nfcd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfcd_pkg::PaddrW-1:0]   paddr,
  input  logic [nfcd_pkg::PdataW-1:0]   pwdata,
  output logic [nfcd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned UsedW =
      (ADDR_BITS < nfcd_pkg::AddrW) ? ADDR_BITS : nfcd_pkg::AddrW;

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StUnlockA  = 3'd1,
    StUnlockB  = 3'd2,
    StProgram  = 3'd3,
    StErasePre = 3'd4,
    StEraseA   = 3'd5,
    StEraseB   = 3'd6
  } step_e;

  // Configuration registers.
  logic [nfcd_pkg::DataW-1:0] maker_id_q, part_id_q;
  logic                       swap_q;

  // Input stage.
  logic                       in_vld_q;
  logic                       kind_q;
  logic [UsedW-1:0]           addr_q;
  logic [nfcd_pkg::DataW-1:0] data_q;

  // Sequence state.
  step_e step_q, step_d;
  logic  id_q, id_d;

  // Result stage.
  logic                       out_vld_q;
  nfcd_pkg::op_e              op_q, op_d;
  logic [nfcd_pkg::AddrW-1:0] taddr_q, taddr_d;
  logic [nfcd_pkg::DataW-1:0] rdata_q, rdata_d;

  logic        accept, adv, wrong, cfg_wr;
  logic [15:0] a16;
  logic [7:0]  cmd, sector_code, block_code;
  logic [nfcd_pkg::AddrW-1:0] addr_ext;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maker_id_q <= nfcd_pkg::MakerIdReset;
      part_id_q  <= nfcd_pkg::PartIdReset;
      swap_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        nfcd_pkg::RegMakerId:   maker_id_q <= pwdata[nfcd_pkg::DataW-1:0];
        nfcd_pkg::RegPartId:    part_id_q  <= pwdata[nfcd_pkg::DataW-1:0];
        nfcd_pkg::RegEraseSwap: swap_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      nfcd_pkg::RegMakerId:   prdata = nfcd_pkg::PdataW'(maker_id_q);
      nfcd_pkg::RegPartId:    prdata = nfcd_pkg::PdataW'(part_id_q);
      nfcd_pkg::RegEraseSwap: prdata = nfcd_pkg::PdataW'(swap_q);
      default:                prdata = '0;
    endcase
  end

  // The input stage moves on whenever the result stage is free or draining.
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign accept     = in_i.valid && in_i.ready;

  assign a16         = addr_q[15:0];
  assign cmd         = data_q[7:0];
  assign addr_ext    = nfcd_pkg::AddrW'(addr_q);
  assign sector_code = swap_q ? nfcd_pkg::CmdEraseHi : nfcd_pkg::CmdEraseLo;
  assign block_code  = swap_q ? nfcd_pkg::CmdEraseLo : nfcd_pkg::CmdEraseHi;

  always_comb begin
    op_d    = nfcd_pkg::OpNone;
    taddr_d = '0;
    rdata_d = '0;
    step_d  = step_q;
    id_d    = id_q;
    wrong   = 1'b0;
    if (!kind_q) begin
      // A read aborts any partial sequence but leaves ID mode alone.
      step_d  = StIdle;
      taddr_d = addr_ext;
      if (id_q && a16 == 16'd0) begin
        op_d    = nfcd_pkg::OpIdRead;
        rdata_d = maker_id_q;
      end else if (id_q && a16 == 16'd1) begin
        op_d    = nfcd_pkg::OpIdRead;
        rdata_d = part_id_q;
      end else begin
        op_d = nfcd_pkg::OpRead;
      end
    end else begin
      case (step_q)
        StUnlockA: begin
          if (a16 == nfcd_pkg::UnlockAddrB && cmd == nfcd_pkg::CmdUnlockB) begin
            step_d = StUnlockB;
          end else begin
            wrong = 1'b1;
          end
        end
        StUnlockB: begin
          step_d = StIdle;
          if (a16 != nfcd_pkg::UnlockAddrA) begin
            wrong = 1'b1;
          end else if (cmd == nfcd_pkg::CmdIdEntry) begin
            id_d = 1'b1;
          end else if (cmd == nfcd_pkg::CmdExit) begin
            id_d = 1'b0;
          end else if (cmd == nfcd_pkg::CmdProgram) begin
            step_d = StProgram;
          end else if (cmd == nfcd_pkg::CmdErase) begin
            step_d = StErasePre;
          end else begin
            wrong = 1'b1;
          end
        end
        StProgram: begin
          step_d  = StIdle;
          op_d    = nfcd_pkg::OpProgram;
          taddr_d = addr_ext;
          rdata_d = data_q;
        end
        StErasePre: begin
          if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdUnlockA) begin
            step_d = StEraseA;
          end else begin
            wrong = 1'b1;
          end
        end
        StEraseA: begin
          if (a16 == nfcd_pkg::UnlockAddrB && cmd == nfcd_pkg::CmdUnlockB) begin
            step_d = StEraseB;
          end else begin
            wrong = 1'b1;
          end
        end
        StEraseB: begin
          step_d = StIdle;
          if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdChip) begin
            op_d = nfcd_pkg::OpChip;
          end else if (cmd == sector_code) begin
            op_d    = nfcd_pkg::OpSector;
            taddr_d = addr_ext;
          end else if (cmd == block_code) begin
            op_d    = nfcd_pkg::OpBlock;
            taddr_d = addr_ext;
          end else begin
            wrong = 1'b1;
          end
        end
        default: begin
          // Idle, and the unused step code, wait for the first unlock write; an exit byte leaves ID mode.
          step_d = StIdle;
          if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdUnlockA) begin
            step_d = StUnlockA;
          end else if (cmd == nfcd_pkg::CmdExit) begin
            id_d = 1'b0;
          end
        end
      endcase
      // A write that breaks the sequence drops back to read mode; an exit
      // byte on it also leaves ID mode.
      if (wrong) begin
        step_d = StIdle;
        if (cmd == nfcd_pkg::CmdExit) begin
          id_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      step_q    <= StIdle;
      id_q      <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        step_q    <= step_d;
        id_q      <= id_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      addr_q <= in_i.word_address[UsedW-1:0];
      data_q <= in_i.write_data;
    end
    if (adv) begin
      op_q    <= op_d;
      taddr_q <= taddr_d;
      rdata_q <= rdata_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.operation      = op_q;
  assign out_o.target_address = taddr_q;
  assign out_o.result_data    = rdata_q;

endmodule

FILE: rtl/core/nfcd_checker.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder checker
// Port-level assertions on the operation channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [nfcd_pkg::OpW-1:0]     operation_i,
  input logic [nfcd_pkg::AddrW-1:0]   target_address_i,
  input logic [nfcd_pkg::DataW-1:0]   result_data_i
);

  // Only defined operation codes leave the block.
  `NFCD_ASSERT_IMPL(a_op_defined, clk_i, rst_ni, out_valid_i, operation_i <= nfcd_pkg::OpW'(nfcd_pkg::OpChip))

  // Chip erase carries neither address nor data.
  `NFCD_ASSERT_IMPL(a_chip_clean, clk_i, rst_ni, out_valid_i && operation_i == nfcd_pkg::OpW'(nfcd_pkg::OpChip), target_address_i == '0 && result_data_i == '0)

  // Array reads and erases return no data word.
  `NFCD_ASSERT_IMPL(a_no_data, clk_i, rst_ni, out_valid_i && (operation_i == nfcd_pkg::OpW'(nfcd_pkg::OpRead) || operation_i == nfcd_pkg::OpW'(nfcd_pkg::OpSector) || operation_i == nfcd_pkg::OpW'(nfcd_pkg::OpBlock)), result_data_i == '0)

  // A result that is not taken stays offered.
  `NFCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind nor_flash_command_decoder_core nfcd_checker u_nfcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .operation_i      (out_o.operation),
  .target_address_i (out_o.target_address),
  .result_data_i    (out_o.result_data)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// NOR flash command decoder testbench
// Drives bus accesses into the decoder with random gaps on both channels and
// predicts the array operation for every word from its own model of the
// unlock/command protocol. It starts with a directed list of accesses, then
// runs random command sequences, broken sequences and noise under four
// register settings, checking every result in order and the registers on
// readback.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic        KindRead    = 1'b0;
  localparam logic        KindWrite   = 1'b1;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;

  localparam int unsigned AddrW  = nfcd_pkg::AddrW;
  localparam int unsigned DataW  = nfcd_pkg::DataW;
  localparam int unsigned PaddrW = nfcd_pkg::PaddrW;
  localparam int unsigned PdataW = nfcd_pkg::PdataW;

  localparam logic [AddrW-1:0] AddrA = {{(AddrW-16){1'b0}}, nfcd_pkg::UnlockAddrA};
  localparam logic [AddrW-1:0] AddrB = {{(AddrW-16){1'b0}}, nfcd_pkg::UnlockAddrB};

  typedef enum logic [2:0] {
    SqIdle     = 3'd0,
    SqUnlock1  = 3'd1,
    SqUnlock2  = 3'd2,
    SqProgram  = 3'd3,
    SqErasePre = 3'd4,
    SqEraseU1  = 3'd5,
    SqEraseU2  = 3'd6
  } seq_e;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } access_t;

  typedef struct packed {
    nfcd_pkg::op_e    op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } result_t;

  typedef struct packed {
    access_t acc;
    bit      chk;
    result_t res;
  } row_t;

  localparam result_t Quiet = '{nfcd_pkg::OpNone, '0, '0};

  // Rows with chk set carry their expected operation; the others rely on the
  // decoder model.
  localparam row_t DirectedRows [30] = '{
    '{'{KindRead,  22'h000000, 16'hFFFF},                       1'b1,
      '{nfcd_pkg::OpRead, 22'h000000, 16'h0}},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdIdEntry}},       1'b1, Quiet},
    '{'{KindRead,  22'h010000, 16'h0000},                       1'b1,
      '{nfcd_pkg::OpIdRead, 22'h010000, nfcd_pkg::MakerIdReset}},
    '{'{KindRead,  22'h3F0001, 16'h0000},                       1'b1,
      '{nfcd_pkg::OpIdRead, 22'h3F0001, nfcd_pkg::PartIdReset}},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdProgram}},       1'b0, Quiet},
    '{'{KindWrite, 22'h3FFFFF, 16'hFFFF},                       1'b1,
      '{nfcd_pkg::OpProgram, 22'h3FFFFF, 16'hFFFF}},
    '{'{KindWrite, 22'h000123, {8'h12, nfcd_pkg::CmdExit}},     1'b1, Quiet},
    '{'{KindRead,  22'h000000, 16'h0000},                       1'b1,
      '{nfcd_pkg::OpRead, 22'h000000, 16'h0}},
    '{'{KindWrite, {6'h3F, nfcd_pkg::UnlockAddrA}, {8'hFF, nfcd_pkg::CmdUnlockA}},
      1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdErase}},         1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdChip}},          1'b1,
      '{nfcd_pkg::OpChip, 22'h0, 16'h0}},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdErase}},         1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, 22'h02ABCD, {8'h00, nfcd_pkg::CmdEraseLo}},  1'b1,
      '{nfcd_pkg::OpSector, 22'h02ABCD, 16'h0}},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdErase}},         1'b0, Quiet},
    '{'{KindWrite, AddrA, {8'h00, nfcd_pkg::CmdUnlockA}},       1'b0, Quiet},
    '{'{KindWrite, AddrB, {8'h00, nfcd_pkg::CmdUnlockB}},       1'b0, Quiet},
    '{'{KindWrite, 22'h000000, {8'h00, nfcd_pkg::CmdEraseHi}},  1'b1,
      '{nfcd_pkg::OpBlock, 22'h0, 16'h0}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  nfcd_in_if  in_ch ();
  nfcd_out_if out_ch ();

  nor_flash_command_decoder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Decoder model state and register copies.
  seq_e            flash_step  = SqIdle;
  logic            in_id_mode  = 1'b0;
  logic [DataW-1:0] cfg_maker  = nfcd_pkg::MakerIdReset;
  logic [DataW-1:0] cfg_part   = nfcd_pkg::PartIdReset;
  logic            cfg_swap    = 1'b0;

  result_t     expected_ops [$];
  access_t     burst [$];
  bit          idle_on       = 1'b1;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned rx_gap        = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned accesses_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned op_tally [8];

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void abort_sequence(logic [7:0] cmd);
    flash_step = SqIdle;
    if (cmd == nfcd_pkg::CmdExit) in_id_mode = 1'b0;
  endfunction

  // Works out the operation one bus access produces and advances the
  // sequence state.
  function automatic result_t decode_access(access_t a);
    result_t    r;
    logic [15:0] a16;
    logic [7:0]  cmd;
    logic [7:0]  sector_cmd;
    logic [7:0]  block_cmd;
    r = Quiet;
    a16 = a.addr[15:0];
    cmd = a.data[7:0];
    sector_cmd = cfg_swap ? nfcd_pkg::CmdEraseHi : nfcd_pkg::CmdEraseLo;
    block_cmd = cfg_swap ? nfcd_pkg::CmdEraseLo : nfcd_pkg::CmdEraseHi;
    if (a.kind == KindRead) begin
      // A read breaks off any partial sequence but leaves ID mode alone.
      flash_step = SqIdle;
      if (in_id_mode && a16 == 16'd0) r = '{nfcd_pkg::OpIdRead, a.addr, cfg_maker};
      else if (in_id_mode && a16 == 16'd1) r = '{nfcd_pkg::OpIdRead, a.addr, cfg_part};
      else r = '{nfcd_pkg::OpRead, a.addr, '0};
      return r;
    end
    case (flash_step)
      SqUnlock1: begin
        if (a16 == nfcd_pkg::UnlockAddrB && cmd == nfcd_pkg::CmdUnlockB) begin
          flash_step = SqUnlock2;
        end else abort_sequence(cmd);
      end
      SqUnlock2: begin
        flash_step = SqIdle;
        if (a16 != nfcd_pkg::UnlockAddrA) abort_sequence(cmd);
        else if (cmd == nfcd_pkg::CmdIdEntry) in_id_mode = 1'b1;
        else if (cmd == nfcd_pkg::CmdExit) in_id_mode = 1'b0;
        else if (cmd == nfcd_pkg::CmdProgram) flash_step = SqProgram;
        else if (cmd == nfcd_pkg::CmdErase) flash_step = SqErasePre;
        else abort_sequence(cmd);
      end
      SqProgram: begin
        flash_step = SqIdle;
        r = '{nfcd_pkg::OpProgram, a.addr, a.data};
      end
      SqErasePre: begin
        if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdUnlockA) begin
          flash_step = SqEraseU1;
        end else abort_sequence(cmd);
      end
      SqEraseU1: begin
        if (a16 == nfcd_pkg::UnlockAddrB && cmd == nfcd_pkg::CmdUnlockB) begin
          flash_step = SqEraseU2;
        end else abort_sequence(cmd);
      end
      SqEraseU2: begin
        flash_step = SqIdle;
        if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdChip) begin
          r = '{nfcd_pkg::OpChip, '0, '0};
        end else if (cmd == sector_cmd) r = '{nfcd_pkg::OpSector, a.addr, '0};
        else if (cmd == block_cmd) r = '{nfcd_pkg::OpBlock, a.addr, '0};
        else abort_sequence(cmd);
      end
      default: begin
        if (a16 == nfcd_pkg::UnlockAddrA && cmd == nfcd_pkg::CmdUnlockA) begin
          flash_step = SqUnlock1;
        end else abort_sequence(cmd);
      end
    endcase
    return r;
  endfunction

  function automatic access_t any_access(logic kind);
    access_t t;
    t.kind = kind;
    t.addr = AddrW'($urandom);
    t.data = DataW'($urandom);
    return t;
  endfunction

  function automatic access_t read_access();
    access_t t;
    t = any_access(KindRead);
    if ($urandom_range(0, 1) == 1) t.addr[15:0] = 16'($urandom_range(0, 2));
    return t;
  endfunction

  // Command cycle with random upper address bits and, now and then, a
  // random upper data byte.
  function automatic access_t cmd_write(logic [15:0] a16, logic [7:0] cmd);
    access_t t;
    t.kind = KindWrite;
    t.addr = {(AddrW-16)'($urandom), a16};
    t.data = {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, cmd};
    return t;
  endfunction

  task automatic make_burst();
    int unsigned pick;
    int unsigned idx;
    access_t     t;
    bit          cut;
    burst.delete();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdUnlockA));
      burst.push_back(cmd_write(nfcd_pkg::UnlockAddrB, nfcd_pkg::CmdUnlockB));
      case ($urandom_range(0, 5))
        0: begin
          burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdIdEntry));
          repeat ($urandom_range(1, 4)) burst.push_back(read_access());
        end
        1: burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdExit));
        2, 3: begin
          burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdProgram));
          burst.push_back(any_access(KindWrite));
        end
        default: begin
          burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdErase));
          burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdUnlockA));
          burst.push_back(cmd_write(nfcd_pkg::UnlockAddrB, nfcd_pkg::CmdUnlockB));
          case ($urandom_range(0, 4))
            0: burst.push_back(cmd_write(nfcd_pkg::UnlockAddrA, nfcd_pkg::CmdChip));
            1: burst.push_back(cmd_write(16'($urandom), nfcd_pkg::CmdEraseLo));
            2: burst.push_back(cmd_write(16'($urandom), nfcd_pkg::CmdEraseHi));
            3: burst.push_back(cmd_write(16'($urandom), nfcd_pkg::CmdChip));
            default: burst.push_back(cmd_write(16'($urandom), 8'($urandom)));
          endcase
        end
      endcase
      // Some sequences get one access damaged or are cut short.
      if (pick >= 55) begin
        idx = $urandom_range(0, burst.size() - 1);
        t = burst[idx];
        cut = 1'b0;
        case ($urandom_range(0, 3))
          0: t.addr = t.addr ^ (AddrW'(1) << $urandom_range(0, 15));
          1: t.data = t.data ^ (DataW'(1) << $urandom_range(0, 7));
          2: t.kind = KindRead;
          default: cut = 1'b1;
        endcase
        if (cut) begin
          while (burst.size() > idx) void'(burst.pop_back());
          burst.push_back(any_access(KindWrite));
        end else begin
          burst[idx] = t;
        end
      end
    end else if (pick < 78) begin
      burst.push_back(cmd_write(16'($urandom), nfcd_pkg::CmdExit));
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) burst.push_back(read_access());
    end else begin
      repeat ($urandom_range(1, 3)) burst.push_back(any_access(1'($urandom)));
    end
  endtask

  task automatic send_access(input access_t a, input bit chk, input result_t res);
    int unsigned gap;
    result_t     predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= a.kind;
    in_ch.word_address <= a.addr;
    in_ch.write_data   <= a.data;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = decode_access(a);
    expected_ops.push_back(chk ? res : predicted);
    accesses_sent++;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = accesses_sent + n;
    while (accesses_sent < stop_at) begin
      make_burst();
      foreach (burst[i]) send_access(burst[i], 1'b0, Quiet);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_ops.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic [1:0] idx, input logic wr,
                            input logic [PdataW-1:0] wdata,
                            output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [PdataW-1:0] rd;
    reg_access(nfcd_pkg::RegMakerId, 1'b0, '0, rd);
    if (rd[DataW-1:0] !== cfg_maker) begin
      $error("maker_id: expected %h, got %h", cfg_maker, rd[DataW-1:0]);
      mismatches++;
    end
    reg_access(nfcd_pkg::RegPartId, 1'b0, '0, rd);
    if (rd[DataW-1:0] !== cfg_part) begin
      $error("part_id: expected %h, got %h", cfg_part, rd[DataW-1:0]);
      mismatches++;
    end
    reg_access(nfcd_pkg::RegEraseSwap, 1'b0, '0, rd);
    if (rd[0] !== cfg_swap) begin
      $error("erase_codes_swapped: expected %0d, got %0d", cfg_swap, rd[0]);
      mismatches++;
    end
  endtask

  task automatic load_config(input logic [DataW-1:0] maker, input logic [DataW-1:0] part,
                             input logic swap);
    logic [PdataW-1:0] rd;
    wait_for_results();
    reg_access(nfcd_pkg::RegMakerId, 1'b1, PdataW'(maker), rd);
    reg_access(nfcd_pkg::RegPartId, 1'b1, PdataW'(part), rd);
    reg_access(nfcd_pkg::RegEraseSwap, 1'b1, PdataW'(swap), rd);
    cfg_maker = maker;
    cfg_part  = part;
    cfg_swap  = swap;
    check_registers();
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    op_tally[out_ch.operation]++;
    if (expected_ops.size() == 0) begin
      $error("unexpected word: operation %0d, address %h, data %h",
             out_ch.operation, out_ch.target_address, out_ch.result_data);
      mismatches++;
      return;
    end
    want = expected_ops.pop_front();
    if (out_ch.operation !== want.op) begin
      $error("operation: expected %0d, got %0d", want.op, out_ch.operation);
      mismatches++;
    end
    if (out_ch.target_address !== want.addr) begin
      $error("target_address: expected %h, got %h", want.addr, out_ch.target_address);
      mismatches++;
    end
    if (out_ch.result_data !== want.data) begin
      $error("result_data: expected %h, got %h", want.data, out_ch.result_data);
      mismatches++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_request) begin
        hold_left = LongHold;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL nor_flash_command_decoder_core");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid        = 1'b0;
    in_ch.kind         = KindRead;
    in_ch.word_address = '0;
    in_ch.write_data   = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_ni             = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_registers();
    foreach (DirectedRows[i]) begin
      send_access(DirectedRows[i].acc, DirectedRows[i].chk, DirectedRows[i].res);
    end
    run_random(450);

    // Swapped erase codes; the result side holds off while accesses keep
    // coming, so the decoder backs up to its input.
    load_config(16'h0000, 16'hFFFF, 1'b1);
    idle_on = 1'b0;
    hold_request = 1'b1;
    run_random(40);
    idle_on = 1'b1;
    run_random(360);

    load_config(16'hFFFF, 16'h0000, 1'b0);
    idle_on = 1'b0;
    run_random(200);
    wait_for_results();
    idle_on = 1'b1;
    run_random(200);

    load_config(16'($urandom), 16'($urandom), 1'($urandom));
    run_random(400);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d bus accesses under four register settings, %0d results checked.",
             accesses_sent, results_seen);
    $display("Array reads %0d, id reads %0d, programs %0d, sector %0d, block %0d, chip %0d.",
             op_tally[nfcd_pkg::OpRead], op_tally[nfcd_pkg::OpIdRead],
             op_tally[nfcd_pkg::OpProgram], op_tally[nfcd_pkg::OpSector],
             op_tally[nfcd_pkg::OpBlock], op_tally[nfcd_pkg::OpChip]);
    if (mismatches == 0) begin
      $display("PASS nor_flash_command_decoder_core");
    end else begin
      $display("FAIL nor_flash_command_decoder_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/nfcd_pkg.sv
rtl/core/nfcd_in_if.sv
rtl/core/nfcd_out_if.sv
rtl/core/nor_flash_command_decoder_core.sv
rtl/core/nfcd_checker.sv
test/testbench.sv
